// ----- src/ipv4_udp_publish_framer_defines.svh -----
// assertion macros for the framer
`ifndef IPV4_UDP_PUBLISH_FRAMER_DEFINES_SVH
`define IPV4_UDP_PUBLISH_FRAMER_DEFINES_SVH

// same-cycle implication
`define IPUF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IPUF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ipuf_pkg.sv -----
package ipuf_pkg;

    localparam int HDR_LEN     = 35;
    localparam int IDX_W       = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_LEN   = 2'd1;
    localparam logic [1:0] ST_NOPKT = 2'd2;

    localparam logic [1:0] REG_SRC_ADDR = 2'd0;
    localparam logic [1:0] REG_DST_ADDR = 2'd1;
    localparam logic [1:0] REG_SPORT    = 2'd2;
    localparam logic [1:0] REG_DPORT    = 2'd3;

    localparam logic [15:0] SPORT_RST = 16'd35000;
    localparam logic [15:0] DPORT_RST = 16'd1883;

    localparam logic [7:0] IP_VER_IHL  = 8'h45;
    localparam logic [7:0] IP_FLAG_DF  = 8'h40;
    localparam logic [7:0] IP_TTL      = 8'h40;
    localparam logic [7:0] IP_PROTO    = 8'h11;
    localparam logic [7:0] MQ_PUBLISH  = 8'h0C;
    localparam logic [7:0] MQ_FLAGS    = 8'h61;
    localparam logic [7:0] MQ_HDR_LEN  = 8'd7;
    localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;
    localparam logic [15:0] IPV4_HDR_BYTES = 16'd20;
    localparam logic [15:0] CK_MASK     = 16'hFFFF;
    // 0x4500 + 0x4000 + 0x4011
    localparam logic [18:0] CK_BASE     = 19'h0C511;

    typedef enum logic [1:0] {
        K_HDR,
        K_DATA,
        K_ERR_LEN,
        K_ERR_NOPKT
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  plen;
        logic [15:0] topic;
        logic [15:0] msg_id;
        logic [7:0]  data;
        logic        pend;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] udp_sport;
        logic [15:0] udp_dport;
    } t_cfg;

endpackage

// ----- src/ipuf_stream_if.sv -----
interface ipuf_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [7:0]  payload_length;
    logic [15:0] topic;
    logic [7:0]  data_byte;

    modport source (output valid, func, payload_length, topic, data_byte, input ready);
    modport sink   (input valid, func, payload_length, topic, data_byte, output ready);
endinterface

interface ipuf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       packet_end;
    logic [1:0] status;

    modport source (output valid, out_byte, last_of_run, packet_end, status, input ready);
    modport sink   (input valid, out_byte, last_of_run, packet_end, status, output ready);
endinterface

// ----- src/ipuf_queue.sv -----
module ipuf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ipuf_pkg::t_push i_push,
    input  logic            i_pop,
    output ipuf_pkg::t_cmd  o_head,
    output logic            o_head_valid,
    output logic            o_full
);

    localparam int PTR_W = $clog2(ipuf_pkg::QUEUE_DEPTH);

    ipuf_pkg::t_cmd r_mem [ipuf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push.valid, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_head_valid = (r_count != '0);
    assign o_full       = (r_count == (PTR_W+1)'(ipuf_pkg::QUEUE_DEPTH));

endmodule

// ----- src/ipuf_front.sv -----
module ipuf_front #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ipuf_in_if.sink          i_req,
    input  logic             i_q_full,
    output ipuf_pkg::t_push  o_push
);

    logic [15:0] r_counter;
    logic [7:0]  r_remaining;
    logic        w_accept;
    logic        w_too_long;
    logic [15:0] w_next_id;

    assign i_req.ready = !i_q_full;
    assign w_accept    = i_req.valid && !i_q_full;
    assign w_too_long  = (i_req.payload_length > 8'(MAX_PAYLOAD));
    assign w_next_id   = r_counter + 16'd1;

    always_comb begin
        o_push.valid      = w_accept;
        o_push.cmd.plen   = i_req.payload_length;
        o_push.cmd.topic  = i_req.topic;
        o_push.cmd.msg_id = w_next_id;
        o_push.cmd.data   = i_req.data_byte;
        o_push.cmd.pend   = 1'b0;
        o_push.cmd.kind   = ipuf_pkg::K_DATA;
        if (!i_req.func) begin
            if (w_too_long) begin
                o_push.cmd.kind = ipuf_pkg::K_ERR_LEN;
            end else begin
                o_push.cmd.kind = ipuf_pkg::K_HDR;
                o_push.cmd.pend = (i_req.payload_length == 8'd0);
            end
        end else if (r_remaining == 8'd0) begin
            o_push.cmd.kind = ipuf_pkg::K_ERR_NOPKT;
        end else begin
            o_push.cmd.pend = (r_remaining == 8'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter   <= '0;
            r_remaining <= '0;
        end else if (w_accept) begin
            if (!i_req.func) begin
                if (w_too_long) begin
                    r_remaining <= '0;
                end else begin
                    r_counter   <= w_next_id;
                    r_remaining <= i_req.payload_length;
                end
            end else if (r_remaining != 8'd0) begin
                r_remaining <= r_remaining - 8'd1;
            end
        end
    end

endmodule

// ----- src/ipuf_back.sv -----
module ipuf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ipuf_pkg::t_cfg i_cfg,
    input  ipuf_pkg::t_cmd i_head,
    input  logic           i_head_valid,
    output logic           o_pop,
    ipuf_out_if.source     o_rsp
);

    logic [ipuf_pkg::IDX_W-1:0] r_idx;
    logic [18:0] r_acc;
    logic [18:0] n_acc;
    logic        r_o_valid;
    logic [7:0]  r_o_byte;
    logic        r_o_last;
    logic        r_o_pend;
    logic [1:0]  r_o_status;

    logic        w_emit;
    logic        w_last;
    logic [7:0]  w_byte;
    logic        w_pend;
    logic [1:0]  w_status;
    logic [7:0]  w_mlen;
    logic [15:0] w_ulen;
    logic [15:0] w_tlen;
    logic [15:0] w_ck;
    logic [7:0]  w_hdr_byte;
    logic        w_hdr_last;

    assign w_emit = i_head_valid && (!r_o_valid || o_rsp.ready);
    assign w_mlen = i_head.plen + ipuf_pkg::MQ_HDR_LEN;
    assign w_ulen = {8'd0, w_mlen} + ipuf_pkg::UDP_HDR_BYTES;
    assign w_tlen = w_ulen + ipuf_pkg::IPV4_HDR_BYTES;
    assign w_ck   = r_acc[15:0] ^ ipuf_pkg::CK_MASK;
    assign w_hdr_last = (r_idx == ipuf_pkg::IDX_W'(ipuf_pkg::HDR_LEN - 1));

    always_comb begin
        case (r_idx)
            6'd0:    w_hdr_byte = ipuf_pkg::IP_VER_IHL;
            6'd2:    w_hdr_byte = w_tlen[15:8];
            6'd3:    w_hdr_byte = w_tlen[7:0];
            6'd4:    w_hdr_byte = i_head.msg_id[15:8];
            6'd5:    w_hdr_byte = i_head.msg_id[7:0];
            6'd6:    w_hdr_byte = ipuf_pkg::IP_FLAG_DF;
            6'd8:    w_hdr_byte = ipuf_pkg::IP_TTL;
            6'd9:    w_hdr_byte = ipuf_pkg::IP_PROTO;
            6'd10:   w_hdr_byte = w_ck[15:8];
            6'd11:   w_hdr_byte = w_ck[7:0];
            6'd12:   w_hdr_byte = i_cfg.src_addr[31:24];
            6'd13:   w_hdr_byte = i_cfg.src_addr[23:16];
            6'd14:   w_hdr_byte = i_cfg.src_addr[15:8];
            6'd15:   w_hdr_byte = i_cfg.src_addr[7:0];
            6'd16:   w_hdr_byte = i_cfg.dst_addr[31:24];
            6'd17:   w_hdr_byte = i_cfg.dst_addr[23:16];
            6'd18:   w_hdr_byte = i_cfg.dst_addr[15:8];
            6'd19:   w_hdr_byte = i_cfg.dst_addr[7:0];
            6'd20:   w_hdr_byte = i_cfg.udp_sport[15:8];
            6'd21:   w_hdr_byte = i_cfg.udp_sport[7:0];
            6'd22:   w_hdr_byte = i_cfg.udp_dport[15:8];
            6'd23:   w_hdr_byte = i_cfg.udp_dport[7:0];
            6'd24:   w_hdr_byte = w_ulen[15:8];
            6'd25:   w_hdr_byte = w_ulen[7:0];
            6'd28:   w_hdr_byte = w_mlen;
            6'd29:   w_hdr_byte = ipuf_pkg::MQ_PUBLISH;
            6'd30:   w_hdr_byte = ipuf_pkg::MQ_FLAGS;
            6'd31:   w_hdr_byte = i_head.topic[15:8];
            6'd32:   w_hdr_byte = i_head.topic[7:0];
            6'd33:   w_hdr_byte = i_head.msg_id[15:8];
            6'd34:   w_hdr_byte = i_head.msg_id[7:0];
            default: w_hdr_byte = 8'd0;
        endcase
    end

    // checksum accumulates one word per header byte over the first six header bytes, then folds twice
    always_comb begin
        case (r_idx)
            6'd0:    n_acc = ipuf_pkg::CK_BASE + {3'd0, w_tlen};
            6'd1:    n_acc = r_acc + {3'd0, i_head.msg_id};
            6'd2:    n_acc = r_acc + {3'd0, i_cfg.src_addr[31:16]};
            6'd3:    n_acc = r_acc + {3'd0, i_cfg.src_addr[15:0]};
            6'd4:    n_acc = r_acc + {3'd0, i_cfg.dst_addr[31:16]};
            6'd5:    n_acc = r_acc + {3'd0, i_cfg.dst_addr[15:0]};
            6'd6,
            6'd7:    n_acc = {3'd0, r_acc[15:0]} + {16'd0, r_acc[18:16]};
            default: n_acc = r_acc;
        endcase
    end

    always_comb begin
        w_byte   = 8'd0;
        w_last   = 1'b1;
        w_pend   = 1'b0;
        w_status = ipuf_pkg::ST_OK;
        unique case (i_head.kind)
            ipuf_pkg::K_HDR: begin
                w_byte = w_hdr_byte;
                w_last = w_hdr_last;
                w_pend = w_hdr_last && i_head.pend;
            end
            ipuf_pkg::K_DATA: begin
                w_byte = i_head.data;
                w_pend = i_head.pend;
            end
            ipuf_pkg::K_ERR_LEN: begin
                w_status = ipuf_pkg::ST_LEN;
            end
            ipuf_pkg::K_ERR_NOPKT: begin
                w_status = ipuf_pkg::ST_NOPKT;
            end
            default: begin
                w_status = ipuf_pkg::ST_OK;
            end
        endcase
    end

    assign o_pop = w_emit && w_last;

    always_ff @(posedge i_clk) begin
        if (w_emit && (i_head.kind == ipuf_pkg::K_HDR)) begin
            r_acc <= n_acc;
        end
        if (w_emit) begin
            r_o_byte   <= w_byte;
            r_o_last   <= w_last;
            r_o_pend   <= w_pend;
            r_o_status <= w_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_idx     <= w_last ? '0 : r_idx + 1'b1;
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.out_byte    = r_o_byte;
    assign o_rsp.last_of_run = r_o_last;
    assign o_rsp.packet_end  = r_o_pend;
    assign o_rsp.status      = r_o_status;

endmodule

// ----- src/ipv4_udp_publish_framer.sv -----
// ipv4/udp/mqtt-sn publish framer
// i_req: request channel (valid/ready). func 0 opens a packet with payload_length
//   and topic, func 1 delivers one payload byte
// o_rsp: byte stream (valid/ready). each request gives a run of results, the last
//   marked last_of_run; the final packet byte carries packet_end
// a start request gives the 35-byte ipv4 + udp + mqtt-sn header; an oversize length
//   or a byte with no open packet gives one result with a nonzero status
// the front classifies requests and keeps the counter and remaining count, a
//   two-entry queue feeds the back, which sends one byte per cycle from an output
//   register while o_rsp is ready and builds the header checksum while the first header bytes go out
// throughput: one payload byte per cycle while o_rsp is ready; a header holds the back for its
//   35 bytes, and the front takes requests until the queue is full
// a stalled o_rsp holds its byte; requests keep queueing until the queue fills
// reset: counter 0, no packet open, addresses 0, ports 35000 and 1883, queue empty
// apb: source_address at 0x0, destination_address 0x4, source_port 0x8,
//   destination_port 0xc; to be written only while idle, the block itself does not enforce this
`include "ipv4_udp_publish_framer_defines.svh"

module ipv4_udp_publish_framer #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ipuf_in_if.sink     i_req,
    ipuf_out_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ipuf_pkg::t_cfg  r_cfg;
    ipuf_pkg::t_push w_push;
    ipuf_pkg::t_cmd  w_head;
    logic            w_head_valid;
    logic            w_q_full;
    logic            w_pop;
    logic            w_cfg_wr;
    logic            w_rsp_err;
    logic            w_err_shape_ok;
    logic            w_run_end;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_addr  <= '0;
            r_cfg.dst_addr  <= '0;
            r_cfg.udp_sport <= ipuf_pkg::SPORT_RST;
            r_cfg.udp_dport <= ipuf_pkg::DPORT_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                ipuf_pkg::REG_SRC_ADDR: r_cfg.src_addr  <= pwdata;
                ipuf_pkg::REG_DST_ADDR: r_cfg.dst_addr  <= pwdata;
                ipuf_pkg::REG_SPORT:    r_cfg.udp_sport <= pwdata[15:0];
                ipuf_pkg::REG_DPORT:    r_cfg.udp_dport <= pwdata[15:0];
                default: r_cfg.src_addr <= r_cfg.src_addr;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            ipuf_pkg::REG_SRC_ADDR: prdata = r_cfg.src_addr;
            ipuf_pkg::REG_DST_ADDR: prdata = r_cfg.dst_addr;
            ipuf_pkg::REG_SPORT:    prdata = {16'd0, r_cfg.udp_sport};
            ipuf_pkg::REG_DPORT:    prdata = {16'd0, r_cfg.udp_dport};
            default: prdata = '0;
        endcase
    end

    ipuf_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_q_full (w_q_full),
        .o_push   (w_push)
    );

    ipuf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_pop        (w_pop),
        .o_head       (w_head),
        .o_head_valid (w_head_valid),
        .o_full       (w_q_full)
    );

    ipuf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head       (w_head),
        .i_head_valid (w_head_valid),
        .o_pop        (w_pop),
        .o_rsp        (o_rsp)
    );

    assign w_rsp_err      = o_rsp.valid && (o_rsp.status != ipuf_pkg::ST_OK);
    assign w_err_shape_ok = o_rsp.last_of_run && !o_rsp.packet_end && (o_rsp.out_byte == 8'd0);
    assign w_run_end      = o_rsp.valid && o_rsp.last_of_run;

    `IPUF_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, w_push.valid, !w_q_full, "queue overflow")
    `IPUF_ASSERT_NOW(a_pop_has_head, i_clk, i_rst_n, w_pop, w_head_valid, "pop from empty queue")
    `IPUF_ASSERT_NOW(a_err_shape, i_clk, i_rst_n, w_rsp_err, w_err_shape_ok, "bad error result")
    `IPUF_ASSERT_NEXT(a_pop_fills_out, i_clk, i_rst_n, w_pop, w_run_end, "run end not presented")

endmodule
